[rtl/core/websocket_frame_decoder_assert.svh]
// Assertion macros shared by the frame decoder RTL.
// Depends on nothing; files that check their logic include this header.
`ifndef WEBSOCKET_FRAME_DECODER_ASSERT_SVH
`define WEBSOCKET_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define WSFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wsfd: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define WSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wsfd: next-cycle check failed");

`endif

[rtl/core/wsfd_pkg.sv]
// Shared types and constants of the WebSocket frame decoder.
// Depends on nothing; every other RTL file but the assertion header imports it.
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OPCODE_W = 4;
   localparam int unsigned LEN_W    = 64;
   localparam int unsigned KEY_W    = 32;
   localparam int unsigned EXT_W    = 4;
   localparam int unsigned KCNT_W   = 3;
   localparam int unsigned KIDX_W   = 2;

   localparam logic [6:0]        LEN_CODE_16  = 7'd126;
   localparam logic [6:0]        LEN_CODE_64  = 7'd127;
   localparam logic [EXT_W-1:0]  EXT_BYTES_16 = 4'd2;
   localparam logic [EXT_W-1:0]  EXT_BYTES_64 = 4'd8;
   localparam logic [KCNT_W-1:0] KEY_BYTE_CNT = 3'd4;

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } wsfd_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic [OPCODE_W-1:0] opcode;
      logic                payload_valid;
      logic [LEN_W-1:0]    frame_length;
      logic                last;
   } wsfd_result_type;

endpackage

`default_nettype wire

[rtl/core/wsfd_req_if.sv]
// Request channel: one raw stream byte per transaction.
// Depends on wsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wsfd_req_if;
   import wsfd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/wsfd_rsp_if.sv]
// Response channel: one decoded payload byte or empty-frame marker per transaction.
// Depends on wsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wsfd_rsp_if;
   import wsfd_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic [OPCODE_W-1:0] opcode;
   logic                payload_valid;
   logic [LEN_W-1:0]    frame_length;
   logic                last;

   modport source (output valid, output out_byte, output opcode, output payload_valid,
                   output frame_length, output last, input ready);
   modport sink   (input valid, input out_byte, input opcode, input payload_valid,
                   input frame_length, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/wsfd_out_reg.sv]
// Result register of the frame decoder; drives the response channel.
// Depends on wsfd_pkg and wsfd_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module wsfd_out_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire wsfd_pkg::wsfd_result_type res,
   output      logic                      slot_free,
   wsfd_rsp_if.source                     rsp_bus
);
   import wsfd_pkg::*;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   wsfd_result_type rsp_data_ff;
   wsfd_result_type rsp_data_in;

   // A new result may land when the register is empty or is drained this cycle.
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_byte      = rsp_data_ff.out_byte;
   assign rsp_bus.opcode        = rsp_data_ff.opcode;
   assign rsp_bus.payload_valid = rsp_data_ff.payload_valid;
   assign rsp_bus.frame_length  = rsp_data_ff.frame_length;
   assign rsp_bus.last          = rsp_data_ff.last;

endmodule

`default_nettype wire

[rtl/core/wsfd_parser.sv]
// Input byte register and frame header/payload parser of the frame decoder.
// Depends on wsfd_pkg, wsfd_req_if and websocket_frame_decoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "websocket_frame_decoder_assert.svh"

module wsfd_parser (
   input  wire logic                      clock,
   input  wire logic                      reset,
   wsfd_req_if.sink                       req_bus,
   input  wire logic                      slot_free,
   output      logic                      load,
   output      wsfd_pkg::wsfd_result_type res
);
   import wsfd_pkg::*;

   // Input register
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [BYTE_W-1:0] in_byte_in;
   logic              req_ready;
   logic              in_take;

   // Parse state
   wsfd_phase_type      phase_ff;
   wsfd_phase_type      phase_in;
   logic [OPCODE_W-1:0] frame_opcode_ff;
   logic [OPCODE_W-1:0] frame_opcode_in;
   logic                masked_ff;
   logic                masked_in;
   logic [EXT_W-1:0]    ext_bytes_left_ff;
   logic [EXT_W-1:0]    ext_bytes_left_in;
   logic [LEN_W-1:0]    payload_total_ff;
   logic [LEN_W-1:0]    payload_total_in;
   logic [LEN_W-1:0]    payload_left_ff;
   logic [LEN_W-1:0]    payload_left_in;
   logic [KEY_W-1:0]    mask_key_ff;
   logic [KEY_W-1:0]    mask_key_in;
   logic [KCNT_W-1:0]   key_cnt_ff;
   logic [KCNT_W-1:0]   key_cnt_in;
   logic [KIDX_W-1:0]   key_index_ff;
   logic [KIDX_W-1:0]   key_index_in;

   // Decode helpers
   logic [BYTE_W-1:0] b;
   logic [6:0]        len_code;
   logic              ext_code;
   logic              ext_done;
   logic              key_done;
   logic              data_last;
   logic              total_zero;
   logic              emit;
   logic [LEN_W-1:0]  total_new;
   logic [BYTE_W-1:0] key_byte;

   assign b          = in_byte_ff;
   assign len_code   = b[6:0];
   assign ext_code   = (len_code == LEN_CODE_16) || (len_code == LEN_CODE_64);
   assign ext_done   = (ext_bytes_left_ff == EXT_W'(1));
   assign key_done   = (key_cnt_ff == KCNT_W'(1));
   assign data_last  = (payload_left_ff == LEN_W'(1));

   // Payload length as it stands after this byte.
   always_comb begin
      unique case (phase_ff)
         PH_HDR1: total_new = ext_code ? '0 : LEN_W'(len_code);
         PH_EXT:  total_new = {payload_total_ff[LEN_W-BYTE_W-1:0], b};
         default: total_new = payload_total_ff;
      endcase
   end

   assign total_zero = (total_new == '0);

   always_comb begin
      unique case (key_index_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   // Result of the byte in the input register, if any
   always_comb begin
      emit = 1'b0;
      unique case (phase_ff)
         PH_HDR1: emit = !ext_code && !b[7] && total_zero;
         PH_EXT:  emit = ext_done && !masked_ff && total_zero;
         PH_KEY:  emit = key_done && total_zero;
         PH_DATA: emit = 1'b1;
         default: emit = 1'b0;
      endcase
   end

   always_comb begin
      res.opcode        = frame_opcode_ff;
      res.frame_length  = total_new;
      if (phase_ff == PH_DATA) begin
         res.out_byte      = b ^ (masked_ff ? key_byte : '0);
         res.payload_valid = 1'b1;
         res.last          = data_last;
      end else begin
         res.out_byte      = '0;
         res.payload_valid = 1'b0;
         res.last          = 1'b1;
      end
   end

   // Hold the byte while its result has nowhere to go.
   assign in_take   = in_valid_ff && (!emit || slot_free);
   assign req_ready = !in_valid_ff || in_take;
   assign load      = in_take && emit;

   assign req_bus.ready = req_ready;

   always_comb begin
      in_valid_in = req_ready ? req_bus.valid : in_valid_ff;
      in_byte_in  = (req_bus.valid && req_ready) ? req_bus.in_byte : in_byte_ff;
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (in_take) begin
         unique case (phase_ff)
            PH_HDR1: begin
               if (ext_code) begin
                  phase_in = PH_EXT;
               end else if (b[7]) begin
                  phase_in = PH_KEY;
               end else begin
                  phase_in = total_zero ? PH_HDR0 : PH_DATA;
               end
            end
            PH_EXT: begin
               if (ext_done) begin
                  if (masked_ff) begin
                     phase_in = PH_KEY;
                  end else begin
                     phase_in = total_zero ? PH_HDR0 : PH_DATA;
                  end
               end
            end
            PH_KEY: begin
               if (key_done) begin
                  phase_in = total_zero ? PH_HDR0 : PH_DATA;
               end
            end
            PH_DATA: begin
               if (data_last) begin
                  phase_in = PH_HDR0;
               end
            end
            default: phase_in = PH_HDR1;
         endcase
      end
   end

   // Frame state updates
   always_comb begin
      frame_opcode_in   = frame_opcode_ff;
      masked_in         = masked_ff;
      ext_bytes_left_in = ext_bytes_left_ff;
      payload_total_in  = payload_total_ff;
      payload_left_in   = payload_left_ff;
      mask_key_in       = mask_key_ff;
      key_cnt_in        = key_cnt_ff;
      key_index_in      = key_index_ff;
      if (in_take) begin
         unique case (phase_ff)
            PH_HDR1: begin
               masked_in        = b[7];
               payload_total_in = total_new;
               if (ext_code) begin
                  ext_bytes_left_in = (len_code == LEN_CODE_64) ? EXT_BYTES_64 : EXT_BYTES_16;
               end else if (b[7]) begin
                  key_cnt_in = KEY_BYTE_CNT;
               end else if (!total_zero) begin
                  payload_left_in = total_new;
                  key_index_in    = '0;
               end
            end
            PH_EXT: begin
               payload_total_in  = total_new;
               ext_bytes_left_in = ext_bytes_left_ff - EXT_W'(1);
               if (ext_done) begin
                  if (masked_ff) begin
                     key_cnt_in = KEY_BYTE_CNT;
                  end else if (!total_zero) begin
                     payload_left_in = total_new;
                     key_index_in    = '0;
                  end
               end
            end
            PH_KEY: begin
               mask_key_in = {mask_key_ff[KEY_W-BYTE_W-1:0], b};
               key_cnt_in  = key_cnt_ff - KCNT_W'(1);
               if (key_done && !total_zero) begin
                  payload_left_in = total_new;
                  key_index_in    = '0;
               end
            end
            PH_DATA: begin
               payload_left_in = payload_left_ff - LEN_W'(1);
               key_index_in    = key_index_ff + KIDX_W'(1);
            end
            default: frame_opcode_in = b[OPCODE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         phase_ff          <= PH_HDR0;
         frame_opcode_ff   <= '0;
         masked_ff         <= 1'b0;
         ext_bytes_left_ff <= '0;
         payload_total_ff  <= '0;
         payload_left_ff   <= '0;
         mask_key_ff       <= '0;
         key_cnt_ff        <= '0;
         key_index_ff      <= '0;
      end else begin
         in_valid_ff       <= in_valid_in;
         phase_ff          <= phase_in;
         frame_opcode_ff   <= frame_opcode_in;
         masked_ff         <= masked_in;
         ext_bytes_left_ff <= ext_bytes_left_in;
         payload_total_ff  <= payload_total_in;
         payload_left_ff   <= payload_left_in;
         mask_key_ff       <= mask_key_in;
         key_cnt_ff        <= key_cnt_in;
         key_index_ff      <= key_index_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   `WSFD_ASSERT_NOW(a_data_left_nonzero, clock, reset, phase_ff == PH_DATA, payload_left_ff != '0)
   `WSFD_ASSERT_NOW(a_key_count_live, clock, reset, phase_ff == PH_KEY, key_cnt_ff != '0)
   `WSFD_ASSERT_NOW(a_ext_count_live, clock, reset, phase_ff == PH_EXT, ext_bytes_left_ff != '0)
   `WSFD_ASSERT_NEXT(a_last_ends_frame, clock, reset, load && res.last, phase_ff == PH_HDR0)

endmodule

`default_nettype wire

[rtl/core/websocket_frame_decoder.sv]
// A byte accepted is held in the input register, parsed and loaded into the response
// register. Throughput: one byte per cycle while the response register has room, set
// by the single-pass parser. Header bytes produce no response but for the last header
// byte of an empty frame; a byte with a result waits while the response register is
// full and not drained. Reset: synchronous, active high; parser returns to awaiting a
// frame's first byte. Depends on wsfd_pkg, interfaces, parser, out_reg.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_decoder (
   input wire logic clock,
   input wire logic reset,
   wsfd_req_if.sink   req_bus,
   wsfd_rsp_if.source rsp_bus
);
   import wsfd_pkg::*;

   logic            load;
   logic            slot_free;
   wsfd_result_type res;

   wsfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .slot_free (slot_free),
      .load      (load),
      .res       (res)
   );

   wsfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .res       (res),
      .slot_free (slot_free),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire
